[rtl/core/wsf_pkg.sv]
// ----------------------------------------------------------------------------
// Wildcard substring finder package
// Shared widths, register indexes, the match status type and helpers.
// ----------------------------------------------------------------------------
package wsf_pkg;

  localparam int PATTERN_MAX     = 16;
  localparam int POSITION_WIDTH  = 16;
  localparam int CHAR_WIDTH      = 8;
  localparam int START_WIDTH     = 16;
  localparam int LEN_WIDTH       = 5;
  localparam int CFG_WIDTH       = 64;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int IDX_WIDTH       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PATTERN_BITS    = PATTERN_MAX * CHAR_WIDTH;

  localparam logic [CHAR_WIDTH-1:0] WILDCARD = 8'd63;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef struct packed {
    logic [PATTERN_MAX-1:0] partial_next;
    logic                   hit;
  } match_t;

  // A length of zero behaves as one, anything above the maximum as the maximum.
  function automatic logic [LEN_WIDTH-1:0] effective_length(
    input logic [LEN_WIDTH-1:0] raw
  );
    logic [LEN_WIDTH-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_WIDTH'(1);
    end else if (raw > LEN_WIDTH'(PATTERN_MAX)) begin
      len = LEN_WIDTH'(PATTERN_MAX);
    end
    return len;
  endfunction

endpackage

[rtl/core/wsf_if.sv]
// ----------------------------------------------------------------------------
// Wildcard substring finder channels
// Valid/ready channels for text characters and per-line results.
// ----------------------------------------------------------------------------
interface wsf_in_if;
  logic                            valid;
  logic                            ready;
  logic [wsf_pkg::CHAR_WIDTH-1:0]  character;
  logic                            end_of_line;

  modport source (output valid, output character, output end_of_line, input ready);
  modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface wsf_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [wsf_pkg::START_WIDTH-1:0] start_position;
  logic                            line_too_long;

  modport source (output valid, output found, output start_position,
                  output line_too_long, input ready);
  modport sink   (input valid, input found, input start_position,
                  input line_too_long, output ready);
endinterface

[rtl/core/wsf_match_unit.sv]
// ----------------------------------------------------------------------------
// Shift-and match unit
// Compares one character against every pattern slot and advances the
// partial match vector by one position.
// ----------------------------------------------------------------------------
module wsf_match_unit (
  input  logic [wsf_pkg::CHAR_WIDTH-1:0]   character,
  input  logic [wsf_pkg::PATTERN_BITS-1:0] pattern,
  input  logic [wsf_pkg::LEN_WIDTH-1:0]    len,
  input  logic [wsf_pkg::PATTERN_MAX-1:0]  partial,
  output wsf_pkg::match_t                  status
);

  logic [wsf_pkg::PATTERN_MAX-1:0] char_mask;
  logic [wsf_pkg::PATTERN_MAX-1:0] shifted;
  logic [wsf_pkg::LEN_WIDTH-1:0]   last_slot;
  logic [wsf_pkg::CHAR_WIDTH-1:0]  slot_char [wsf_pkg::PATTERN_MAX];

  always_comb begin
    for (int k = 0; k < wsf_pkg::PATTERN_MAX; k++) begin
      slot_char[k] = pattern[k*wsf_pkg::CHAR_WIDTH +: wsf_pkg::CHAR_WIDTH];
      char_mask[k] = ((slot_char[k] == character) || (slot_char[k] == wsf_pkg::WILDCARD))
                     && (wsf_pkg::LEN_WIDTH'(k) < len);
    end
  end

  // Bit 0 always restarts; slots past the length are masked off above.
  if (wsf_pkg::PATTERN_MAX > 1) begin : g_shift
    assign shifted = {partial[wsf_pkg::PATTERN_MAX-2:0], 1'b1};
  end else begin : g_single
    assign shifted = 1'b1;
  end

  assign last_slot           = len - 1'b1;
  assign status.partial_next = shifted & char_mask;
  assign status.hit          = status.partial_next[last_slot[wsf_pkg::IDX_WIDTH-1:0]];

endmodule

[rtl/core/wsf_line_tracker.sv]
// ----------------------------------------------------------------------------
// Line state and result register
// Holds per-line match state and position count, and registers one result
// at the end of each line.
// ----------------------------------------------------------------------------
module wsf_line_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             end_of_line,
  input  wsf_pkg::match_t                  status,
  input  logic [wsf_pkg::LEN_WIDTH-1:0]    len,
  output logic [wsf_pkg::PATTERN_MAX-1:0]  partial,
  output logic                             out_free,
  wsf_out_if.source                        result_out
);

  localparam logic [wsf_pkg::POSITION_WIDTH-1:0] COUNT_MAX = '1;

  logic [wsf_pkg::POSITION_WIDTH-1:0] char_count;
  logic                               match_seen;
  logic [wsf_pkg::START_WIDTH-1:0]    match_start;
  logic                               overflow_seen;

  logic                               overflow_now;
  logic                               new_match;
  logic [wsf_pkg::POSITION_WIDTH-1:0] char_count_next;
  logic                               match_seen_next;
  logic [wsf_pkg::START_WIDTH-1:0]    match_start_next;
  logic                               overflow_seen_next;

  always_comb begin
    overflow_now       = (char_count == COUNT_MAX);
    char_count_next    = overflow_now ? char_count : char_count + 1'b1;
    // Only the first match is kept; all matches have the same length, so it
    // is also the leftmost one.
    new_match          = !match_seen && !overflow_now && status.hit;
    match_seen_next    = match_seen || new_match;
    match_start_next   = new_match
                       ? wsf_pkg::START_WIDTH'(char_count_next
                           - wsf_pkg::POSITION_WIDTH'(len) + 1'b1)
                       : match_start;
    overflow_seen_next = overflow_seen || overflow_now;
  end

  assign out_free = !result_out.valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial       <= '0;
      char_count    <= '0;
      match_seen    <= 1'b0;
      match_start   <= '0;
      overflow_seen <= 1'b0;
    end else if (step) begin
      if (end_of_line) begin
        partial       <= '0;
        char_count    <= '0;
        match_seen    <= 1'b0;
        match_start   <= '0;
        overflow_seen <= 1'b0;
      end else begin
        partial       <= status.partial_next;
        char_count    <= char_count_next;
        match_seen    <= match_seen_next;
        match_start   <= match_start_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (step && end_of_line) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && end_of_line) begin
      result_out.found          <= match_seen_next;
      result_out.start_position <= match_seen_next ? match_start_next : '0;
      result_out.line_too_long  <= overflow_seen_next;
    end
  end

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    step && end_of_line |=> char_count == '0 && !match_seen && partial == '0)
    else $error("line state not cleared after end of line");

  a_no_start_without_match: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.found |-> result_out.start_position == '0)
    else $error("start position set on a line without a match");

  a_start_nonzero: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> match_start != '0)
    else $error("recorded match has a zero start position");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    step && end_of_line |-> out_free)
    else $error("end of line taken while the result register is still full");

endmodule

[rtl/core/wildcard_substring_finder_top.sv]
// ----------------------------------------------------------------------------
// Wildcard substring finder
// Finds the leftmost occurrence of a pattern with '?' wildcards in each text
// line and reports one result per line.
// ----------------------------------------------------------------------------
//  channel      dir  request contents
//  text_in      in   character, end_of_line (one character per request)
//  result_out   out  found, start_position, line_too_long (one per line)
//  cfg_*        in   pattern_low, pattern_high, pattern_length writes
//
// Each character passes an input register and the shift-and logic; one
// character per cycle is sustained unless an end of line stalls. A result is
// registered as its end of line leaves the input register; a stalled result
// only holds back the next end of line. Synchronous reset clears the line
// state and both valid flags and restores the pattern registers.
// ----------------------------------------------------------------------------
module wildcard_substring_finder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  wsf_in_if.sink                               text_in,
  wsf_out_if.source                            result_out,
  input  logic                                 cfg_write,
  input  logic [wsf_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wsf_pkg::CFG_WIDTH-1:0]        cfg_data
);

  logic [wsf_pkg::CFG_WIDTH-1:0]   pattern_low;
  logic [wsf_pkg::CFG_WIDTH-1:0]   pattern_high;
  logic [wsf_pkg::LEN_WIDTH-1:0]   pattern_length;
  logic [wsf_pkg::LEN_WIDTH-1:0]   len;
  logic [wsf_pkg::PATTERN_BITS-1:0] pattern;

  logic                            stage_valid;
  logic [wsf_pkg::CHAR_WIDTH-1:0]  stage_char;
  logic                            stage_eol;
  logic                            step;
  logic                            out_free;
  logic [wsf_pkg::PATTERN_MAX-1:0] partial;
  wsf_pkg::match_t                 status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= wsf_pkg::LEN_WIDTH'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        wsf_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        wsf_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        wsf_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[wsf_pkg::LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign len     = wsf_pkg::effective_length(pattern_length);
  assign pattern = wsf_pkg::PATTERN_BITS'({pattern_high, pattern_low});

  // Ordinary characters always move on; an end of line waits for the result slot.
  assign step          = stage_valid && (!stage_eol || out_free);
  assign text_in.ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text_in.ready) begin
      stage_valid <= text_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_in.ready && text_in.valid) begin
      stage_char <= text_in.character;
      stage_eol  <= text_in.end_of_line;
    end
  end

  wsf_match_unit u_match (
    .character (stage_char),
    .pattern   (pattern),
    .len       (len),
    .partial   (partial),
    .status    (status)
  );

  wsf_line_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .end_of_line (stage_eol),
    .status      (status),
    .len         (len),
    .partial     (partial),
    .out_free    (out_free),
    .result_out  (result_out)
  );

endmodule

[tb/wildcard_substring_finder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard substring finder testbench
// Streams text lines into the finder under random sender bursts and result
// stalls, tracks the shift-and match state of every line, and checks each
// per-line result against the tracked answer. Covers reset defaults,
// wildcards, pattern length clamping and random patterns.
// ----------------------------------------------------------------------------
module wildcard_substring_finder_top_test;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic                            found;
    logic [wsf_pkg::START_WIDTH-1:0] start_position;
    logic                            line_too_long;
  } line_result_t;

  logic clk;
  logic rst;
  logic                                cfg_write;
  logic [wsf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [wsf_pkg::CFG_WIDTH-1:0]       cfg_data;

  wsf_in_if  text_in ();
  wsf_out_if result_out ();

  wildcard_substring_finder_top uut (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .result_out (result_out),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Pattern as the block holds it, and the line state of the current line.
  logic [63:0]                        pat_lo;
  logic [63:0]                        pat_hi;
  logic [wsf_pkg::LEN_WIDTH-1:0]      pat_len;
  logic [wsf_pkg::PATTERN_MAX-1:0]    partial_bits;
  logic [wsf_pkg::POSITION_WIDTH-1:0] char_cnt;
  logic                               match_seen;
  logic [wsf_pkg::START_WIDTH-1:0]    match_start;
  logic                               overflow_seen;

  line_result_t awaited_results[$];

  int unsigned mismatches    = 0;
  int unsigned lines_checked = 0;
  int unsigned lines_found   = 0;
  int unsigned lines_long    = 0;
  int unsigned chars_sent    = 0;
  int unsigned random_chars  = 0;
  int unsigned burst_left    = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  bit          free_run      = 1'b0;

  always #10 clk = ~clk;

  function automatic int unsigned active_length();
    int unsigned len;
    len = pat_len;
    if (len == 0) len = 1;
    if (len > wsf_pkg::PATTERN_MAX) len = wsf_pkg::PATTERN_MAX;
    return len;
  endfunction

  function automatic logic [63:0] alpha_word();
    logic [63:0] w;
    int k;
    for (k = 0; k < 8; k++) begin
      w[8*k +: 8] = ($urandom_range(0, 4) == 0) ? wsf_pkg::WILDCARD
                                                : 8'(8'h61 + $urandom_range(0, 3));
    end
    return w;
  endfunction

  // Advances the line state by one accepted character and queues the line
  // result when the character closes the line.
  task automatic scan_character(input logic [7:0] c, input logic eol);
    int unsigned len, k;
    logic [127:0] pats;
    logic [wsf_pkg::PATTERN_MAX-1:0] hit_mask;
    logic [wsf_pkg::PATTERN_MAX-1:0] len_mask;
    logic overflow_now;
    line_result_t res;
    len = active_length();
    pats = {pat_hi, pat_lo};
    hit_mask = '0;
    for (k = 0; k < len; k++) begin
      if (pats[8*k +: 8] == c || pats[8*k +: 8] == wsf_pkg::WILDCARD) hit_mask[k] = 1'b1;
    end
    len_mask = (len == wsf_pkg::PATTERN_MAX) ? '1
                                             : wsf_pkg::PATTERN_MAX'((32'd1 << len) - 1);
    partial_bits = ((partial_bits << 1) | wsf_pkg::PATTERN_MAX'(1)) & hit_mask & len_mask;
    overflow_now = (char_cnt == '1);
    if (overflow_now) begin
      overflow_seen = 1'b1;
    end else begin
      char_cnt = char_cnt + 1'b1;
    end
    if (!match_seen && !overflow_now && partial_bits[len-1]) begin
      match_seen = 1'b1;
      match_start = wsf_pkg::START_WIDTH'(char_cnt - wsf_pkg::POSITION_WIDTH'(len) + 1'b1);
    end
    if (eol) begin
      res.found = match_seen;
      res.start_position = match_seen ? match_start : '0;
      res.line_too_long = overflow_seen;
      awaited_results.insert(awaited_results.size(), res);
      partial_bits = '0;
      char_cnt = '0;
      match_seen = 1'b0;
      match_start = '0;
      overflow_seen = 1'b0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic eol);
    int unsigned gap;
    if (!free_run && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        text_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    text_in.valid <= 1'b1;
    text_in.character <= c;
    text_in.end_of_line <= eol;
    @(posedge clk);
    while (!text_in.ready) @(posedge clk);
    scan_character(c, eol);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close_line);
    int k;
    for (k = 0; k < s.len(); k++) begin
      send_char(s[k], close_line && (k == s.len() - 1));
    end
  endtask

  // Stops the sender and waits until every line result has been taken.
  task automatic drain_results();
    text_in.valid <= 1'b0;
    @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [wsf_pkg::LEN_WIDTH-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= wsf_pkg::REG_PATTERN_LOW;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= wsf_pkg::REG_PATTERN_HIGH;
    cfg_data <= hi;
    @(negedge clk);
    // Only the low bits of the length register are meaningful.
    cfg_index <= wsf_pkg::REG_PATTERN_LENGTH;
    cfg_data <= {(wsf_pkg::CFG_WIDTH-wsf_pkg::LEN_WIDTH)'({$urandom, $urandom}), len};
    @(negedge clk);
    cfg_write <= 1'b0;
    pat_lo = lo;
    pat_hi = hi;
    pat_len = len;
  endtask

  task automatic flag_mismatch(input string field, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatches < 20) begin
      $display("mismatch on line %0d: %s is %0h, expected %0h",
               lines_checked, field, got, want);
    end
    mismatches++;
  endtask

  task automatic test_reset_defaults();
    // After reset the pattern is a single zero byte.
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  task automatic test_wildcards();
    load_pattern(64'h0000_0000_0063_3F61, 64'h0, 5'd3);
    send_text("aXc", 1'b1);
    send_text("aXaYc", 1'b1);
    send_text("abcadc", 1'b1);
    send_text("ab", 1'b1);
  endtask

  task automatic test_length_clamp();
    int k;
    load_pattern(64'h0000_0000_0000_00FF, 64'h0, 5'd0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    drain_results();
    load_pattern({8{wsf_pkg::WILDCARD}}, {8{wsf_pkg::WILDCARD}}, 5'd31);
    for (k = 0; k < 16; k++) send_char(8'($urandom_range(0, 255)), k == 15);
  endtask

  task automatic send_random_line();
    logic [7:0] text[$];
    logic [127:0] pats;
    int unsigned n, len, at, k;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
    text = {};
    for (k = 0; k < n; k++) begin
      text = {text, (($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'(8'h61 + $urandom_range(0, 3)))};
    end
    len = active_length();
    pats = {pat_hi, pat_lo};
    // Most lines carry a copy of the pattern with random fill for wildcards.
    if (len <= n && $urandom_range(0, 9) < 6) begin
      at = $urandom_range(0, n - len);
      for (k = 0; k < len; k++) begin
        if (pats[8*k +: 8] != wsf_pkg::WILDCARD) text[at + k] = pats[8*k +: 8];
      end
    end
    for (k = 0; k < n; k++) send_char(text[k], k == n - 1);
    random_chars += n;
  endtask

  task automatic test_random_lines();
    int unsigned phase, lines, k, r, lsel;
    logic [63:0] lo, hi;
    logic [wsf_pkg::LEN_WIDTH-1:0] len;
    phase = 0;
    while (random_chars < 500) begin
      r = $urandom_range(0, 9);
      if (phase == 0 || r == 0) begin
        lo = '1;
        hi = '1;
      end else if (r == 1) begin
        lo = '0;
        hi = '0;
      end else if (phase == 1 || r == 2) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end else begin
        lo = alpha_word();
        hi = alpha_word();
      end
      lsel = $urandom_range(0, 9);
      if (phase == 0 || lsel == 1) begin
        len = 5'd16;
      end else if (lsel == 0) begin
        len = 5'($urandom_range(0, 31));
      end else begin
        len = 5'($urandom_range(1, 6));
      end
      load_pattern(lo, hi, len);
      free_run = (phase == 2);
      lines = $urandom_range(3, 7);
      for (k = 0; k < lines; k++) begin
        if (phase == 3 && k == 2) drain_results();
        send_random_line();
      end
      drain_results();
      free_run = 1'b0;
      phase++;
    end
  endtask

  always @(negedge clk) begin
    if (free_run) begin
      result_out.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (result_out.ready) begin
      result_out.ready <= 1'b0;
      hold_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
    end else begin
      result_out.ready <= 1'b1;
      hold_left <= $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin : check_results
    line_result_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with no line pending", 16'h0, 16'h0);
      end else begin
        want = awaited_results.pop_front();
        if (result_out.found !== want.found)
          flag_mismatch("found", 16'(result_out.found), 16'(want.found));
        if (result_out.start_position !== want.start_position)
          flag_mismatch("start_position", result_out.start_position, want.start_position);
        if (result_out.line_too_long !== want.line_too_long)
          flag_mismatch("line_too_long", 16'(result_out.line_too_long),
                        16'(want.line_too_long));
        if (want.found) lines_found++;
        if (want.line_too_long) lines_long++;
      end
      lines_checked++;
    end
  end

  always @(posedge clk) begin
    if ((text_in.valid && text_in.ready) || (result_out.valid && result_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("[wildcard_substring_finder_top] ERROR");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    text_in.valid = 1'b0;
    text_in.character = '0;
    text_in.end_of_line = 1'b0;
    pat_lo = '0;
    pat_hi = '0;
    pat_len = wsf_pkg::LEN_WIDTH'(1);
    partial_bits = '0;
    char_cnt = '0;
    match_seen = 1'b0;
    match_start = '0;
    overflow_seen = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    drain_results();
    test_wildcards();
    drain_results();
    test_length_clamp();
    drain_results();
    test_random_lines();
    repeat (10) @(negedge clk);

    $display("checked %0d lines from %0d characters: %0d with a match, %0d past the counter",
             lines_checked, chars_sent, lines_found, lines_long);
    if (mismatches == 0) begin
      $display("[wildcard_substring_finder_top] OK");
    end else begin
      $display("[wildcard_substring_finder_top] ERROR");
    end
    $finish;
  end

endmodule
